>>> rtl/fstp_pkg.sv
// Fuzzy self-tuning PID: shared types, fuzzy set breakpoints and rule tables.
// No dependencies; imported by fuzzy_self_tuning_pid_unit.
package fstp_pkg;

   localparam int SETS_MAX = 7;

   typedef logic [2:0]          set_idx_type;
   typedef logic [16:0]         grade_type;
   typedef logic signed [27:0]  err_type;
   typedef logic [30:0]         gain_type;

   typedef enum logic [2:0] {
      CSR_P_GAIN  = 3'd0,
      CSR_I_GAIN  = 3'd1,
      CSR_D_GAIN  = 3'd2,
      CSR_FLOOR   = 3'd3,
      CSR_CEILING = 3'd4
   } csr_idx_type;

   // left foot, peak, right foot (units)
   localparam int SET_PTS [SETS_MAX][3] = '{
      '{-3, -3, -2}, '{-3, -2, 0}, '{-3, -1, 1}, '{-2, 0, 2},
      '{-1, 1, 3},   '{0, 2, 3},   '{2, 3, 3}};

   localparam logic [2:0] P_TABLE [SETS_MAX][SETS_MAX] = '{
      '{6, 6, 5, 5, 4, 3, 3}, '{6, 6, 5, 4, 4, 3, 2}, '{5, 5, 5, 4, 3, 2, 2},
      '{5, 5, 4, 3, 2, 1, 1}, '{4, 4, 3, 2, 2, 1, 1}, '{4, 3, 2, 1, 1, 1, 0},
      '{3, 3, 1, 1, 1, 0, 0}};
   localparam logic [2:0] I_TABLE [SETS_MAX][SETS_MAX] = '{
      '{0, 0, 1, 1, 2, 3, 3}, '{0, 0, 1, 2, 2, 3, 3}, '{0, 1, 2, 2, 3, 4, 4},
      '{1, 1, 2, 3, 4, 5, 5}, '{1, 2, 3, 4, 4, 5, 6}, '{3, 3, 4, 4, 5, 6, 6},
      '{3, 3, 4, 5, 5, 6, 6}};
   localparam logic [2:0] D_TABLE [SETS_MAX][SETS_MAX] = '{
      '{4, 2, 0, 0, 0, 1, 4}, '{4, 2, 0, 1, 1, 2, 3}, '{3, 2, 1, 1, 2, 2, 3},
      '{3, 2, 2, 2, 2, 2, 3}, '{3, 3, 3, 3, 3, 3, 3}, '{6, 2, 4, 4, 4, 4, 6},
      '{6, 5, 5, 5, 4, 4, 6}};

   // ceil(2^28 / 50): floor(y / 50) = (y * DIV50_MUL) >> 28 for y < 2^22
   localparam logic signed [24:0] DIV50_MUL = 25'sd5368710;

   // triangular membership, signed Q12.16 input, result 0..65536
   function automatic grade_type member(input err_type x, input int k);
      logic signed [29:0] xa;
      logic signed [29:0] a;
      logic signed [29:0] b;
      logic signed [29:0] c;
      logic signed [29:0] v;
      grade_type r;
      xa = 30'(x);
      a  = 30'(SET_PTS[k][0] * 65536);
      b  = 30'(SET_PTS[k][1] * 65536);
      c  = 30'(SET_PTS[k][2] * 65536);
      r  = '0;
      if (xa > a && xa <= b) begin
         v = xa - a;
         r = (SET_PTS[k][1] - SET_PTS[k][0] == 1) ? v[16:0] : v[17:1] + 17'(v[0]);
      end else if (xa > b && xa <= c) begin
         v = c - xa;
         r = (SET_PTS[k][2] - SET_PTS[k][1] == 1) ? v[16:0] : v[17:1] + 17'(v[0]);
      end
      return r;
   endfunction

   // defuzzification numerator plus 100 rounding and 400000 bias (keeps it positive)
   function automatic logic [21:0] defuzz_num(input logic [2:0] idx, input grade_type w);
      int a;
      int b;
      int c;
      int v;
      a = 0;
      b = 0;
      c = 0;
      for (int k = 0; k < SETS_MAX; k++) begin
         if (idx == 3'(k)) begin
            a = SET_PTS[k][0];
            b = SET_PTS[k][1];
            c = SET_PTS[k][2];
         end
      end
      v = ((b - a) - (c - b)) * int'(w) + (a + c) * 65536 + 400100;
      return v[21:0];
   endfunction

endpackage

>>> rtl/fuzzy_self_tuning_pid_unit.sv
// Fuzzy self-tuning PID unit: top level, sequencer around one shared multiplier.
// Depends on fstp_pkg (set breakpoints, rule tables, membership helpers).
//
// Usage:
//  req_ channel carries one sample (setpoint, measurement); rsp_ channel returns the
//  clamped drive value and the tuned P, I and D gains for that sample.
//  csr_ port writes gains and output limits; writing a gain also loads the live gain.
//  Each request runs from accept to the next accept through scaling, error and
//  fuzzification, the rule search (one rule cell per cycle, SET_COUNT squared
//  cells), defuzzification, the PID update, the load of the output register and
//  the return to idle.
//  Divide, defuzzify and PID products use one 25x29 multiplier with a registered product.
//  req_tready is high only while the sequencer is idle; one request at a time.
//  The result sits in an output register; a new request is taken while it waits,
//  and its own result is held back until rsp_tready takes the older one.
//  Reset clears gains, limits, error history, accumulator and fired rule cell.
//  A stalled receiver just holds rsp_tvalid and rsp_tdata steady.
module fuzzy_self_tuning_pid_unit #(
   parameter int FUZZY_SETS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // target_value, measured_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [127:0]           rsp_tdata,   // drive_value, p_gain, i_gain, d_gain, pad
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata
);
   import fstp_pkg::*;

   localparam int SET_COUNT = (FUZZY_SETS < SETS_MAX) ? FUZZY_SETS : SETS_MAX;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE_T, ST_SCALE_M, ST_ERROR, ST_FUZZ, ST_INFER,
      ST_DEFUZZ, ST_TUNE, ST_PID, ST_FINISH, ST_DONE
   } state_type;

   state_type               state_ff;
   logic signed [15:0]      tgt_ff, meas_ff;
   err_type                 qt_ff, err_ff, last_err_ff;
   gain_type                gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [31:0]      floor_ff, ceil_ff, accum_ff;
   grade_type               es_ff [SETS_MAX];
   grade_type               ds_ff [SETS_MAX];
   grade_type               best_ff;
   set_idx_type             row_ff, col_ff, frow_ff, fcol_ff;
   logic [1:0]              sel_ff;
   logic [2:0]              pid_ff;
   logic signed [53:0]      prod_ff;
   logic signed [62:0]      macc_ff;
   logic                    rsp_valid_ff;
   logic [127:0]            rsp_data_ff;

   logic signed [24:0]      mul_a;
   logic signed [28:0]      mul_b;
   logic [31:0]             gsum;
   logic [2:0]              def_idx;
   logic signed [14:0]      delta;
   logic signed [32:0]      tuned_raw;
   gain_type                tuned;
   logic signed [27:0]      q_scaled;
   logic signed [15:0]      scale_src;
   logic signed [15:0]      q_src;
   logic [21:0]             scale_y;
   err_type                 de;
   grade_type               rule_grade;
   logic signed [62:0]      term;
   logic signed [62:0]      rnd;
   logic signed [47:0]      sum48;
   logic signed [31:0]      clamped;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign gsum      = {1'b0, gain_p_ff} + {1'b0, gain_i_ff};
   assign scale_src = (state_ff == ST_SCALE_T) ? tgt_ff : meas_ff;
   assign q_src     = (state_ff == ST_SCALE_M) ? tgt_ff : meas_ff;
   assign scale_y   = 22'($signed(23'(scale_src) * 23'sd36) + 23'sd1180025);
   assign q_scaled  = 28'(q_src) * 28'sd1310 + 28'($signed({1'b0, prod_ff[43:28]}))
                      - 28'sd23600;
   assign de        = err_ff - last_err_ff;
   assign rule_grade = (es_ff[row_ff] < ds_ff[col_ff]) ? es_ff[row_ff] : ds_ff[col_ff];

   always_comb begin
      unique case (sel_ff)
         2'd0:    def_idx = P_TABLE[frow_ff][fcol_ff];
         2'd1:    def_idx = I_TABLE[frow_ff][fcol_ff];
         default: def_idx = D_TABLE[frow_ff][fcol_ff];
      endcase
   end

   assign delta = $signed({1'b0, prod_ff[43:30]}) - 15'sd2000;

   always_comb begin
      unique case (sel_ff)
         2'd0:    tuned_raw = $signed({2'b0, gain_p_ff}) + 33'(delta);
         2'd1:    tuned_raw = $signed({2'b0, gain_i_ff}) + 33'(delta);
         default: tuned_raw = $signed({2'b0, gain_d_ff}) + 33'(delta);
      endcase
      if (tuned_raw[32])
         tuned = '0;
      else if (tuned_raw[31])
         tuned = '1;
      else
         tuned = tuned_raw[30:0];
   end

   always_comb begin
      mul_a = DIV50_MUL;
      mul_b = 29'($signed({1'b0, scale_y}));
      unique case (state_ff)
         ST_DEFUZZ: mul_b = 29'($signed({1'b0, defuzz_num(def_idx, best_ff)}));
         ST_PID: begin
            unique case (pid_ff[1:0])
               2'd0: begin
                  mul_a = $signed({9'b0, gsum[15:0]});
                  mul_b = 29'(err_ff);
               end
               2'd1: begin
                  mul_a = $signed({9'b0, gsum[31:16]});
                  mul_b = 29'(err_ff);
               end
               2'd2: begin
                  mul_a = $signed({9'b0, gain_p_ff[15:0]});
                  mul_b = 29'(last_err_ff);
               end
               default: begin
                  mul_a = $signed({10'b0, gain_p_ff[30:16]});
                  mul_b = 29'(last_err_ff);
               end
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      term = 63'(prod_ff);
      unique case (pid_ff - 3'd1)
         3'd0:    term = 63'(prod_ff);
         3'd1:    term = 63'(prod_ff) <<< 16;
         3'd2:    term = -63'(prod_ff);
         default: term = -(63'(prod_ff) <<< 16);
      endcase
   end

   assign rnd   = (macc_ff + 63'sd32768) >>> 16;
   assign sum48 = 48'(accum_ff) + $signed(rnd[47:0]);

   always_comb begin
      if (sum48 > 48'(ceil_ff))
         clamped = ceil_ff;
      else if (sum48 < 48'(floor_ff))
         clamped = floor_ff;
      else
         clamped = sum48[31:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         floor_ff     <= '0;
         ceil_ff      <= '0;
         accum_ff     <= '0;
         last_err_ff  <= '0;
         frow_ff      <= '0;
         fcol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE)
            rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            priority case (csr_index)
               CSR_P_GAIN:  gain_p_ff <= csr_wdata[30:0];
               CSR_I_GAIN:  gain_i_ff <= csr_wdata[30:0];
               CSR_D_GAIN:  gain_d_ff <= csr_wdata[30:0];
               CSR_FLOOR:   floor_ff  <= csr_wdata;
               CSR_CEILING: ceil_ff   <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  tgt_ff   <= req_tdata[15:0];
                  meas_ff  <= req_tdata[31:16];
                  state_ff <= ST_SCALE_T;
               end
            end
            ST_SCALE_T: state_ff <= ST_SCALE_M;
            ST_SCALE_M: begin
               qt_ff    <= q_scaled;
               state_ff <= ST_ERROR;
            end
            ST_ERROR: begin
               err_ff   <= qt_ff - q_scaled;
               state_ff <= ST_FUZZ;
            end
            ST_FUZZ: begin
               for (int k = 0; k < SETS_MAX; k++) begin
                  es_ff[k] <= member(err_ff, k);
                  ds_ff[k] <= member(de, k);
               end
               best_ff  <= '0;
               row_ff   <= '0;
               col_ff   <= '0;
               state_ff <= ST_INFER;
            end
            ST_INFER: begin
               if (rule_grade > best_ff) begin
                  best_ff <= rule_grade;
                  frow_ff <= row_ff;
                  fcol_ff <= col_ff;
               end
               if (col_ff == set_idx_type'(SET_COUNT - 1)) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 3'd1;
                  if (row_ff == set_idx_type'(SET_COUNT - 1)) begin
                     sel_ff   <= '0;
                     state_ff <= ST_DEFUZZ;
                  end
               end else begin
                  col_ff <= col_ff + 3'd1;
               end
            end
            ST_DEFUZZ: state_ff <= ST_TUNE;
            ST_TUNE: begin
               unique case (sel_ff)
                  2'd0:    gain_p_ff <= tuned;
                  2'd1:    gain_i_ff <= tuned;
                  default: gain_d_ff <= tuned;
               endcase
               if (sel_ff == 2'd2) begin
                  pid_ff   <= '0;
                  macc_ff  <= '0;
                  state_ff <= ST_PID;
               end else begin
                  sel_ff   <= sel_ff + 2'd1;
                  state_ff <= ST_DEFUZZ;
               end
            end
            ST_PID: begin
               if (pid_ff != 3'd0)
                  macc_ff <= macc_ff + term;
               pid_ff <= pid_ff + 3'd1;
               if (pid_ff == 3'd4)
                  state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               accum_ff    <= clamped;
               last_err_ff <= err_ff;
               state_ff    <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {3'b0, gain_d_ff, gain_i_ff, gain_p_ff, accum_ff};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
